// File: sv/utfd_pkg.sv
package utfd_pkg;

   localparam int BYTE_W = 8;
   localparam int CP_W   = 21;

   localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;

   typedef enum logic [2:0] {
      LEAD_END,
      LEAD_ASCII,
      LEAD_TWO,
      LEAD_THREE,
      LEAD_FOUR,
      LEAD_BAD
   } lead_type;

   // Results caused by one text byte: a burst of replacement characters
   // for a broken sequence, then at most one closing result.
   typedef struct packed {
      logic [1:0]      repl_count;
      logic            fin_valid;
      logic [CP_W-1:0] fin_cp;
      logic            fin_repl;
      logic            fin_end;
   } run_type;

   function automatic lead_type lead_class(input logic [BYTE_W-1:0] b);
      lead_type c;
      if (b == '0) begin
         c = LEAD_END;
      end else if (b[7] == 1'b0) begin
         c = LEAD_ASCII;
      end else if (b[7:5] == 3'b110) begin
         c = LEAD_TWO;
      end else if (b[7:4] == 4'b1110) begin
         c = LEAD_THREE;
      end else if (b[7:3] == 5'b11110) begin
         c = LEAD_FOUR;
      end else begin
         c = LEAD_BAD;
      end
      return c;
   endfunction

endpackage

// File: sv/utfd_decode.sv
module utfd_decode
   import utfd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  logic [BYTE_W-1:0] text_byte,
   output run_type           run
);

   logic [2:0]      exp_ff, exp_in;
   logic [1:0]      seen_ff, seen_in;
   logic [CP_W-1:0] pv_ff, pv_in;

   logic            pending;
   logic            cont;
   logic [2:0]      seen_plus;
   logic [CP_W-1:0] pv_shift;

   always_comb begin
      pending   = (exp_ff > 3'd1);
      cont      = (text_byte[7:6] == 2'b10);
      seen_plus = {1'b0, seen_ff} + 3'd1;
      pv_shift  = {pv_ff[CP_W-7:0], text_byte[5:0]};

      run     = '0;
      exp_in  = exp_ff;
      seen_in = seen_ff;
      pv_in   = pv_ff;

      if (pending && cont) begin
         if (seen_plus >= exp_ff) begin
            run.fin_valid = 1'b1;
            run.fin_cp    = pv_shift;
            exp_in        = '0;
            seen_in       = '0;
            pv_in         = '0;
         end else begin
            seen_in = seen_plus[1:0];
            pv_in   = pv_shift;
         end
      end else begin
         // A broken sequence gives one replacement per byte received so far.
         run.repl_count = pending ? seen_ff : 2'd0;
         exp_in  = '0;
         seen_in = '0;
         pv_in   = '0;
         unique case (lead_class(text_byte))
            LEAD_END: begin
               run.fin_valid = 1'b1;
               run.fin_end   = 1'b1;
            end
            LEAD_ASCII: begin
               run.fin_valid = 1'b1;
               run.fin_cp    = CP_W'(text_byte);
            end
            LEAD_TWO: begin
               exp_in  = 3'd2;
               seen_in = 2'd1;
               pv_in   = CP_W'(text_byte[4:0]);
            end
            LEAD_THREE: begin
               exp_in  = 3'd3;
               seen_in = 2'd1;
               pv_in   = CP_W'(text_byte[3:0]);
            end
            LEAD_FOUR: begin
               exp_in  = 3'd4;
               seen_in = 2'd1;
               pv_in   = CP_W'(text_byte[2:0]);
            end
            default: begin
               run.fin_valid = 1'b1;
               run.fin_cp    = REPL_CP;
               run.fin_repl  = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ff  <= '0;
         seen_ff <= '0;
         pv_ff   <= '0;
      end else if (take) begin
         exp_ff  <= exp_in;
         seen_ff <= seen_in;
         pv_ff   <= pv_in;
      end
   end

endmodule

// File: sv/utfd_emit.sv
module utfd_emit
   import utfd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  run_type         run_in,
   output logic            can_take,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [CP_W-1:0] rsp_code_point,
   output logic            rsp_is_replacement,
   output logic            rsp_is_end,
   output logic            rsp_last_of_run
);

   logic [1:0]      rem_ff, rem_in;
   logic            fin_ff, fin_in;
   logic [CP_W-1:0] fin_cp_ff;
   logic            fin_repl_ff;
   logic            fin_end_ff;

   logic            valid_ff, valid_in;
   logic [CP_W-1:0] cp_ff, cp_in;
   logic            repl_ff, repl_in;
   logic            end_ff, end_in;
   logic            last_ff, last_in;

   logic run_empty;
   logic out_load;
   logic piece_last;

   always_comb begin
      run_empty  = (rem_ff == 2'd0) && !fin_ff;
      out_load   = !valid_ff || !rsp_stall;
      piece_last = ((rem_ff == 2'd1) && !fin_ff) || ((rem_ff == 2'd0) && fin_ff);
      // The next item's run may enter as the last piece of this one leaves.
      can_take   = run_empty || (out_load && piece_last);

      rem_in = rem_ff;
      fin_in = fin_ff;
      if (out_load && !run_empty) begin
         if (rem_ff != 2'd0) begin
            rem_in = rem_ff - 2'd1;
         end else begin
            fin_in = 1'b0;
         end
      end

      valid_in = !run_empty;
      if (rem_ff != 2'd0) begin
         cp_in   = REPL_CP;
         repl_in = 1'b1;
         end_in  = 1'b0;
         last_in = piece_last;
      end else begin
         cp_in   = fin_cp_ff;
         repl_in = fin_repl_ff;
         end_in  = fin_end_ff;
         last_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff   <= '0;
         fin_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         if (load) begin
            rem_ff <= run_in.repl_count;
            fin_ff <= run_in.fin_valid;
         end else begin
            rem_ff <= rem_in;
            fin_ff <= fin_in;
         end
         if (out_load) begin
            valid_ff <= valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         fin_cp_ff   <= run_in.fin_cp;
         fin_repl_ff <= run_in.fin_repl;
         fin_end_ff  <= run_in.fin_end;
      end
      if (out_load) begin
         cp_ff   <= cp_in;
         repl_ff <= repl_in;
         end_ff  <= end_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_code_point     = cp_ff;
   assign rsp_is_replacement = repl_ff;
   assign rsp_is_end         = end_ff;
   assign rsp_last_of_run    = last_ff;

endmodule

// File: sv/utf8_codepoint_decoder.sv
// UTF-8 to code point decoder.
//
// Input channel (req_): one text byte per item; a zero byte ends the text.
// Result channel (rsp_): one code point per item, with flags for a
// replacement character, the end marker and the last result of a byte.
// A byte gives zero to four results: a lead byte of a multi-byte sequence
// gives none, a broken sequence gives one U+FFFD per buffered byte before
// the result of the byte itself.
//
// From the edge that accepts a byte to the first edge that can accept its
// first result, the byte passes the input register, the run register
// loaded by the decode step, and the result register.
// Throughput is one byte per cycle while each byte gives at most one result
// and the receiver does not stall; any byte with more holds the input until
// its last result is loaded, as the result register takes one per cycle.
//
// Reset (synchronous) drops any pending sequence and all queued results.
// When the receiver stalls, the result register holds its item and the
// stall reaches req_stall once the input register and the run are full.
module utf8_codepoint_decoder
   import utfd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [BYTE_W-1:0] req_text_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [CP_W-1:0]   rsp_code_point,
   output logic              rsp_is_replacement,
   output logic              rsp_is_end,
   output logic              rsp_last_of_run
);

   logic              byte_valid_ff;
   logic [BYTE_W-1:0] byte_ff;
   logic              can_take;
   logic              take;
   run_type           run;

   assign take      = byte_valid_ff && can_take;
   assign req_stall = byte_valid_ff && !can_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         byte_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         byte_ff <= req_text_byte;
      end
   end

   utfd_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .text_byte (byte_ff),
      .run       (run)
   );

   utfd_emit u_emit (
      .clock              (clock),
      .reset              (reset),
      .load               (take),
      .run_in             (run),
      .can_take           (can_take),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_code_point     (rsp_code_point),
      .rsp_is_replacement (rsp_is_replacement),
      .rsp_is_end         (rsp_is_end),
      .rsp_last_of_run    (rsp_last_of_run)
   );

endmodule

// File: sv/utfd_checker.sv
module utfd_checker
   import utfd_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [CP_W-1:0]   rsp_code_point,
   input logic              rsp_is_replacement,
   input logic              rsp_is_end,
   input logic              rsp_last_of_run
);

   // A result that waits on the receiver stays offered and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_code_point)
         && $stable(rsp_is_replacement) && $stable(rsp_is_end)
         && $stable(rsp_last_of_run))
      else $error("result changed while stalled");

   // Only replacement characters of a broken sequence precede the last result.
   a_not_last_is_repl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |-> rsp_is_replacement && !rsp_is_end)
      else $error("non-final result is not a replacement");

   a_end_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_end |-> rsp_last_of_run && !rsp_is_replacement
         && (rsp_code_point == '0))
      else $error("malformed end marker");

   a_repl_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_replacement |-> rsp_code_point == REPL_CP)
      else $error("replacement flag without U+FFFD");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("results or stall survive reset");

endmodule

bind utf8_codepoint_decoder utfd_checker u_utfd_checker (
   .clock              (clock),
   .reset              (reset),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_code_point     (rsp_code_point),
   .rsp_is_replacement (rsp_is_replacement),
   .rsp_is_end         (rsp_is_end),
   .rsp_last_of_run    (rsp_last_of_run)
);
